// ----- src/dtlv_pkg.sv -----
`timescale 1ns / 1ps

package dtlv_pkg;

   localparam int SizeWidth     = 21;
   localparam int ByteWidth     = 8;
   localparam int LenCountWidth = 4;

   localparam logic [SizeWidth-1:0] MaxBuffer = SizeWidth'(1048576);
   localparam logic [6:0] MaxLenBytes = 7'(8);

   typedef enum logic [2:0] {
      EV_TAG = 3'd0,
      EV_LEN = 3'd1,
      EV_HDR = 3'd2,
      EV_VAL = 3'd3,
      EV_ERR = 3'd4
   } event_type;

   typedef enum logic [2:0] {
      ERR_NONE     = 3'd0,
      ERR_TRUNC    = 3'd1,
      ERR_BADCOUNT = 3'd2,
      ERR_TOOLONG  = 3'd3,
      ERR_PAST     = 3'd4
   } error_type;

   typedef enum logic [3:0] {
      PH_TAG   = 4'b0001,
      PH_LEN1  = 4'b0010,
      PH_LENN  = 4'b0100,
      PH_VALUE = 4'b1000
   } phase_type;

   typedef struct packed {
      event_type              event_res;
      logic [ByteWidth-1:0]   tag_value;
      logic [SizeWidth-1:0]   item_length;
      logic [ByteWidth-1:0]   value_byte;
      logic                   last_of_value;
      error_type              error_code;
      logic [SizeWidth-1:0]   byte_offset;
   } rsp_beat_type;

endpackage

// ----- src/dtlv_req_if.sv -----
`timescale 1ns / 1ps

interface dtlv_req_if import dtlv_pkg::*;;
   logic                 valid;
   logic                 ready;
   logic [ByteWidth-1:0] data_byte;

   modport source (output valid, output data_byte, input ready);
   modport sink (input valid, input data_byte, output ready);
endinterface

// ----- src/dtlv_rsp_if.sv -----
`timescale 1ns / 1ps

interface dtlv_rsp_if import dtlv_pkg::*;;
   logic                 valid;
   logic                 ready;
   logic [2:0]           event_res;
   logic [ByteWidth-1:0] tag_value;
   logic [SizeWidth-1:0] item_length;
   logic [ByteWidth-1:0] value_byte;
   logic                 last_of_value;
   logic [2:0]           error_code;
   logic [SizeWidth-1:0] byte_offset;

   modport source (output valid, output event_res, output tag_value, output item_length,
                   output value_byte, output last_of_value, output error_code,
                   output byte_offset, input ready);
   modport sink (input valid, input event_res, input tag_value, input item_length,
                 input value_byte, input last_of_value, input error_code,
                 input byte_offset, output ready);
endinterface

// ----- src/dtlv_in_stage.sv -----
`timescale 1ns / 1ps

module dtlv_in_stage import dtlv_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [ByteWidth-1:0] req_data_byte,
   input  logic                 take,
   output logic                 step,
   output logic [ByteWidth-1:0] byte_out
);

   logic                 valid_ff, valid_in;
   logic [ByteWidth-1:0] byte_ff, byte_in;

   // The held byte moves on when the result register can take it.
   assign step      = valid_ff & take;
   assign req_ready = ~valid_ff | step;
   assign byte_out  = byte_ff;

   always_comb begin
      valid_in = valid_ff;
      byte_in  = byte_ff;
      if (req_ready) begin
         valid_in = req_valid;
         byte_in  = req_data_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      byte_ff <= byte_in;
   end

endmodule

// ----- src/dtlv_decoder.sv -----
`timescale 1ns / 1ps

module dtlv_decoder import dtlv_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_write_enable,
   input  logic [SizeWidth-1:0] csr_write_data,
   input  logic                 step,
   input  logic [ByteWidth-1:0] data_byte,
   output rsp_beat_type         beat
);

   logic [SizeWidth-1:0]     size_ff, size_in;
   phase_type                phase_ff, phase_in;
   logic [ByteWidth-1:0]     tag_ff, tag_in;
   logic [SizeWidth-1:0]     acc_ff, acc_in;
   logic                     big_ff, big_in;
   logic [LenCountWidth-1:0] left_ff, left_in;
   logic [SizeWidth-1:0]     vleft_ff, vleft_in;
   logic [SizeWidth-1:0]     pos_ff, pos_in;
   error_type                err_ff, err_in;

   logic [SizeWidth-1:0]     size_eff;
   logic                     past_end;
   logic [SizeWidth-1:0]     rem;
   logic [6:0]               count;
   logic [SizeWidth-1:0]     acc_shift;
   logic                     big_shift;
   logic [LenCountWidth-1:0] left_dec;
   logic [SizeWidth-1:0]     vleft_dec;
   logic [SizeWidth-1:0]     short_len;

   assign size_eff  = (size_ff > MaxBuffer) ? MaxBuffer : size_ff;
   assign past_end  = pos_ff >= size_eff;
   assign rem       = size_eff - pos_ff - SizeWidth'(1);
   assign count     = data_byte[6:0];
   assign short_len = SizeWidth'(data_byte[6:0]);

   // Only the low bits of the long-form length are kept; anything shifted out
   // above them already exceeds every possible remainder.
   assign acc_shift = {acc_ff[SizeWidth-ByteWidth-1:0], data_byte};
   assign big_shift = big_ff | (|acc_ff[SizeWidth-1:SizeWidth-ByteWidth]);
   assign left_dec  = left_ff - LenCountWidth'(1);
   assign vleft_dec = (vleft_ff != '0) ? vleft_ff - SizeWidth'(1) : vleft_ff;

   always_comb begin
      size_in  = size_ff;
      phase_in = phase_ff;
      tag_in   = tag_ff;
      acc_in   = acc_ff;
      big_in   = big_ff;
      left_in  = left_ff;
      vleft_in = vleft_ff;
      pos_in   = pos_ff;
      err_in   = err_ff;

      beat               = '0;
      beat.event_res     = EV_ERR;
      beat.error_code    = ERR_NONE;
      beat.byte_offset   = pos_ff;

      if (err_ff == ERR_NONE && past_end) begin
         err_in = ERR_PAST;
      end else if (err_ff == ERR_NONE) begin
         case (phase_ff)
            PH_TAG: begin
               tag_in = data_byte;
               if (rem == '0) begin
                  err_in = ERR_TRUNC;
               end else begin
                  beat.event_res = EV_TAG;
                  phase_in       = PH_LEN1;
               end
            end
            PH_LEN1: begin
               if (data_byte[7]) begin
                  if (count == '0 || count > MaxLenBytes
                      || SizeWidth'(count) > rem) begin
                     err_in = ERR_BADCOUNT;
                  end else begin
                     beat.event_res = EV_LEN;
                     acc_in         = '0;
                     big_in         = 1'b0;
                     left_in        = count[LenCountWidth-1:0];
                     phase_in       = PH_LENN;
                  end
               end else if (short_len > rem) begin
                  err_in = ERR_TOOLONG;
               end else begin
                  beat.event_res     = EV_HDR;
                  beat.item_length   = short_len;
                  beat.last_of_value = (short_len == '0);
                  vleft_in           = short_len;
                  phase_in           = (short_len == '0) ? PH_TAG : PH_VALUE;
               end
            end
            PH_LENN: begin
               acc_in  = acc_shift;
               big_in  = big_shift;
               left_in = left_dec;
               if (left_dec != '0) begin
                  beat.event_res = EV_LEN;
               end else if (big_shift || acc_shift > rem) begin
                  err_in = ERR_TOOLONG;
               end else begin
                  beat.event_res     = EV_HDR;
                  beat.item_length   = acc_shift;
                  beat.last_of_value = (acc_shift == '0);
                  vleft_in           = acc_shift;
                  phase_in           = (acc_shift == '0) ? PH_TAG : PH_VALUE;
               end
            end
            PH_VALUE: begin
               beat.event_res  = EV_VAL;
               beat.value_byte = data_byte;
               vleft_in        = vleft_dec;
               if (vleft_dec == '0) begin
                  beat.last_of_value = 1'b1;
                  phase_in           = PH_TAG;
               end
            end
            default: begin
               phase_in = PH_TAG;
            end
         endcase
         if (err_in == ERR_NONE) begin
            pos_in = pos_ff + SizeWidth'(1);
         end
      end

      // Once an error is raised every beat reports it and the offset freezes.
      if (err_in != ERR_NONE) begin
         beat.event_res     = EV_ERR;
         beat.item_length   = '0;
         beat.value_byte    = '0;
         beat.last_of_value = 1'b0;
         beat.error_code    = err_in;
      end
      beat.tag_value = tag_in;

      if (csr_write_enable) begin
         size_in = csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || csr_write_enable) begin
         size_ff  <= reset ? '0 : size_in;
         phase_ff <= PH_TAG;
         tag_ff   <= '0;
         acc_ff   <= '0;
         big_ff   <= 1'b0;
         left_ff  <= '0;
         vleft_ff <= '0;
         pos_ff   <= '0;
         err_ff   <= ERR_NONE;
      end else if (step) begin
         phase_ff <= phase_in;
         tag_ff   <= tag_in;
         acc_ff   <= acc_in;
         big_ff   <= big_in;
         left_ff  <= left_in;
         vleft_ff <= vleft_in;
         pos_ff   <= pos_in;
         err_ff   <= err_in;
      end
   end

endmodule

// ----- src/dtlv_out_stage.sv -----
`timescale 1ns / 1ps

module dtlv_out_stage import dtlv_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         step,
   input  rsp_beat_type beat_in,
   output logic         take,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_beat_type beat_out
);

   logic         valid_ff, valid_in;
   rsp_beat_type beat_ff, beat_in_d;

   assign take      = ~valid_ff | rsp_ready;
   assign rsp_valid = valid_ff;
   assign beat_out  = beat_ff;

   always_comb begin
      valid_in  = valid_ff;
      beat_in_d = beat_ff;
      if (take) begin
         valid_in  = step;
         beat_in_d = beat_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      beat_ff <= beat_in_d;
   end

endmodule

// ----- src/der_tlv_stream_parser.sv -----
`timescale 1ns / 1ps

// Channel   Direction  Handshake          Payload
// req_if    in         valid/ready        data_byte
// rsp_if    out        valid/ready        event_res, tag_value, item_length, value_byte,
//                                         last_of_value, error_code, byte_offset
// csr       in         csr_write_enable   csr_write_data (buffer_size)
//
// One byte per cycle sustained while rsp_if is ready; each byte moves from the input
// register through the decoder into the result register. The parser state is a
// handful of small counters, updated as each byte leaves the input register.
// Reset is synchronous and active high; a buffer_size write restarts parsing.
// A stalled result holds its register; the input register still takes one byte.

module der_tlv_stream_parser import dtlv_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_write_enable,
   input  logic [SizeWidth-1:0] csr_write_data,
   dtlv_req_if.sink             req_if,
   dtlv_rsp_if.source           rsp_if
);

   logic                 take;
   logic                 step;
   logic [ByteWidth-1:0] held_byte;
   rsp_beat_type         beat;
   rsp_beat_type         rsp_beat;

   dtlv_in_stage u_in_stage (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_if.valid),
      .req_ready     (req_if.ready),
      .req_data_byte (req_if.data_byte),
      .take          (take),
      .step          (step),
      .byte_out      (held_byte)
   );

   dtlv_decoder u_decoder (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .step             (step),
      .data_byte        (held_byte),
      .beat             (beat)
   );

   dtlv_out_stage u_out_stage (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .beat_in   (beat),
      .take      (take),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .beat_out  (rsp_beat)
   );

   assign rsp_if.event_res     = rsp_beat.event_res;
   assign rsp_if.tag_value     = rsp_beat.tag_value;
   assign rsp_if.item_length   = rsp_beat.item_length;
   assign rsp_if.value_byte    = rsp_beat.value_byte;
   assign rsp_if.last_of_value = rsp_beat.last_of_value;
   assign rsp_if.error_code    = rsp_beat.error_code;
   assign rsp_if.byte_offset   = rsp_beat.byte_offset;

endmodule

// ----- test/der_tlv_stream_parser_test.sv -----
`timescale 1ns / 1ps

module der_tlv_stream_parser_test;
   import dtlv_pkg::*;

   localparam int ItemTarget = 1750;
   localparam int CycleLimit = 600000;
   localparam int HoldCycles = 150;
   localparam int DrainCycles = 8;

   typedef struct packed {
      logic                 write_size;
      logic [SizeWidth-1:0] size;
      logic [ByteWidth-1:0] data;
      logic                 typed;
      rsp_beat_type         beat;
   } script_row_type;

   localparam rsp_beat_type NoBeat = '0;

   // Directed opening: size writes and bytes, with the obvious outcomes typed in.
   localparam script_row_type Script [33] = '{
      '{1'b0, 21'd0, 8'h30, 1'b1, '{EV_ERR, 8'h00, 21'd0, 8'h00, 1'b0, ERR_PAST, 21'd0}},
      '{1'b1, 21'd1, 8'h00, 1'b0, NoBeat},
      '{1'b0, 21'd0, 8'hA5, 1'b1, '{EV_ERR, 8'hA5, 21'd0, 8'h00, 1'b0, ERR_TRUNC, 21'd0}},
      '{1'b1, 21'd12, 8'h00, 1'b0, NoBeat},
      '{1'b0, 21'd0, 8'h00, 1'b1, '{EV_TAG, 8'h00, 21'd0, 8'h00, 1'b0, ERR_NONE, 21'd0}},
      '{1'b0, 21'd0, 8'h00, 1'b1, '{EV_HDR, 8'h00, 21'd0, 8'h00, 1'b1, ERR_NONE, 21'd1}},
      '{1'b0, 21'd0, 8'hFF, 1'b1, '{EV_TAG, 8'hFF, 21'd0, 8'h00, 1'b0, ERR_NONE, 21'd2}},
      '{1'b0, 21'd0, 8'h81, 1'b0, NoBeat},
      '{1'b0, 21'd0, 8'h02, 1'b0, NoBeat},
      '{1'b0, 21'd0, 8'h00, 1'b0, NoBeat},
      '{1'b0, 21'd0, 8'hFF, 1'b0, NoBeat},
      '{1'b0, 21'd0, 8'h30, 1'b0, NoBeat},
      '{1'b0, 21'd0, 8'h80, 1'b1, '{EV_ERR, 8'h30, 21'd0, 8'h00, 1'b0, ERR_BADCOUNT, 21'd8}},
      '{1'b1, 21'd20, 8'h00, 1'b0, NoBeat},
      '{1'b0, 21'd0, 8'h02, 1'b0, NoBeat},
      '{1'b0, 21'd0, 8'h89, 1'b1, '{EV_ERR, 8'h02, 21'd0, 8'h00, 1'b0, ERR_BADCOUNT, 21'd1}},
      '{1'b1, 21'd4, 8'h00, 1'b0, NoBeat},
      '{1'b0, 21'd0, 8'h02, 1'b0, NoBeat},
      '{1'b0, 21'd0, 8'h83, 1'b1, '{EV_ERR, 8'h02, 21'd0, 8'h00, 1'b0, ERR_BADCOUNT, 21'd1}},
      '{1'b1, 21'd5, 8'h00, 1'b0, NoBeat},
      '{1'b0, 21'd0, 8'h01, 1'b0, NoBeat},
      '{1'b0, 21'd0, 8'h04, 1'b1, '{EV_ERR, 8'h01, 21'd0, 8'h00, 1'b0, ERR_TOOLONG, 21'd1}},
      '{1'b1, MaxBuffer, 8'h00, 1'b0, NoBeat},
      '{1'b0, 21'd0, 8'h1F, 1'b0, NoBeat},
      '{1'b0, 21'd0, 8'h88, 1'b0, NoBeat},
      '{1'b0, 21'd0, 8'hFF, 1'b0, NoBeat},
      '{1'b0, 21'd0, 8'h00, 1'b0, NoBeat},
      '{1'b0, 21'd0, 8'h00, 1'b0, NoBeat},
      '{1'b0, 21'd0, 8'h00, 1'b0, NoBeat},
      '{1'b0, 21'd0, 8'h00, 1'b0, NoBeat},
      '{1'b0, 21'd0, 8'h00, 1'b0, NoBeat},
      '{1'b0, 21'd0, 8'h00, 1'b0, NoBeat},
      '{1'b0, 21'd0, 8'h00, 1'b1, '{EV_ERR, 8'h1F, 21'd0, 8'h00, 1'b0, ERR_TOOLONG, 21'd9}}
   };

   logic                 clock;
   logic                 reset;
   logic                 csr_write_enable;
   logic [SizeWidth-1:0] csr_write_data;

   dtlv_req_if req_bus ();
   dtlv_rsp_if rsp_bus ();

   der_tlv_stream_parser u_dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_if           (req_bus),
      .rsp_if           (rsp_bus)
   );

   // Parser state as seen by the testbench.
   logic [SizeWidth-1:0] size_reg = '0;
   phase_type            parse_phase = PH_TAG;
   logic [ByteWidth-1:0] item_tag = '0;
   logic [63:0]          length_acc = '0;
   logic [3:0]           length_left = '0;
   logic [SizeWidth-1:0] value_left = '0;
   logic [SizeWidth-1:0] byte_pos = '0;
   error_type            parse_error = ERR_NONE;

   rsp_beat_type predicted_events [$];

   bit no_gaps = 1'b0;
   bit long_hold = 1'b0;
   int cycle_count = 0;
   int mismatches = 0;
   int bytes_sent = 0;
   int live_bytes = 0;
   int size_writes = 0;
   int holds_done = 0;
   int beats_checked = 0;
   int header_beats = 0;
   int value_beats = 0;
   int error_beats = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic rsp_beat_type decode_byte(input logic [ByteWidth-1:0] b);
      rsp_beat_type         r;
      logic [SizeWidth-1:0] size_eff;
      logic [SizeWidth-1:0] after_this;
      logic [6:0]           count;
      logic                 hdr_done;
      logic [SizeWidth-1:0] hdr_len;
      r = '0;
      r.event_res = EV_ERR;
      r.byte_offset = byte_pos;
      hdr_done = 1'b0;
      hdr_len = '0;
      size_eff = (size_reg > MaxBuffer) ? MaxBuffer : size_reg;
      if (parse_error == ERR_NONE && byte_pos >= size_eff) begin
         parse_error = ERR_PAST;
      end
      if (parse_error == ERR_NONE) begin
         after_this = size_eff - byte_pos - SizeWidth'(1);
         case (parse_phase)
            PH_TAG: begin
               item_tag = b;
               if (after_this == 0) begin
                  parse_error = ERR_TRUNC;
               end else begin
                  r.event_res = EV_TAG;
                  parse_phase = PH_LEN1;
               end
            end
            PH_LEN1: begin
               if (b[7]) begin
                  count = b[6:0];
                  if (count == 0 || count > MaxLenBytes || count > after_this) begin
                     parse_error = ERR_BADCOUNT;
                  end else begin
                     r.event_res = EV_LEN;
                     length_acc = '0;
                     length_left = count[3:0];
                     parse_phase = PH_LENN;
                  end
               end else if (b > after_this) begin
                  parse_error = ERR_TOOLONG;
               end else begin
                  hdr_done = 1'b1;
                  hdr_len = SizeWidth'(b);
               end
            end
            PH_LENN: begin
               length_acc = {length_acc[55:0], b};
               length_left = length_left - 1'b1;
               if (length_left != 0) begin
                  r.event_res = EV_LEN;
               end else if (length_acc > 64'(after_this)) begin
                  parse_error = ERR_TOOLONG;
               end else begin
                  hdr_done = 1'b1;
                  hdr_len = length_acc[SizeWidth-1:0];
               end
            end
            default: begin
               r.event_res = EV_VAL;
               r.value_byte = b;
               if (value_left != 0) begin
                  value_left = value_left - 1'b1;
               end
               if (value_left == 0) begin
                  r.last_of_value = 1'b1;
                  parse_phase = PH_TAG;
               end
            end
         endcase
         if (hdr_done) begin
            r.event_res = EV_HDR;
            r.item_length = hdr_len;
            value_left = hdr_len;
            r.last_of_value = (hdr_len == 0);
            parse_phase = (hdr_len == 0) ? PH_TAG : PH_VALUE;
         end
         if (parse_error == ERR_NONE) begin
            byte_pos = byte_pos + 1'b1;
         end
      end
      if (parse_error != ERR_NONE) begin
         r.event_res = EV_ERR;
         r.item_length = '0;
         r.value_byte = '0;
         r.last_of_value = 1'b0;
      end
      r.tag_value = item_tag;
      r.error_code = (r.event_res == EV_ERR) ? parse_error : ERR_NONE;
      return r;
   endfunction

   // Waits until the parser has delivered everything, then writes the size
   // register, which also restarts parsing at offset zero.
   task automatic write_buffer_size(input logic [SizeWidth-1:0] value);
      req_bus.valid <= 1'b0;
      while (predicted_events.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      size_reg = value;
      parse_phase = PH_TAG;
      item_tag = '0;
      length_acc = '0;
      length_left = '0;
      value_left = '0;
      byte_pos = '0;
      parse_error = ERR_NONE;
      size_writes++;
   endtask

   task automatic send_byte(input logic [ByteWidth-1:0] b, input logic typed,
                            input rsp_beat_type typed_beat);
      int           gap;
      rsp_beat_type predicted;
      gap = no_gaps ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.data_byte <= b;
      do @(posedge clock); while (!req_bus.ready);
      if (parse_error == ERR_NONE) begin
         live_bytes++;
      end
      bytes_sent++;
      predicted = decode_byte(b);
      predicted_events = {predicted_events, (typed ? typed_beat : predicted)};
   endtask

   initial begin : result_side
      int           stall;
      rsp_beat_type got;
      rsp_beat_type want;
      rsp_bus.ready <= 1'b0;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         if (long_hold) begin
            // Keep the result side blocked long enough for the input to back up.
            long_hold = 1'b0;
            rsp_bus.ready <= 1'b0;
            repeat (HoldCycles) @(posedge clock);
         end
         stall = no_gaps ? 0 : $urandom_range(0, 11);
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (rsp_bus.valid !== 1'b1);
         got.event_res = event_type'(rsp_bus.event_res);
         got.tag_value = rsp_bus.tag_value;
         got.item_length = rsp_bus.item_length;
         got.value_byte = rsp_bus.value_byte;
         got.last_of_value = rsp_bus.last_of_value;
         got.error_code = error_type'(rsp_bus.error_code);
         got.byte_offset = rsp_bus.byte_offset;
         beats_checked++;
         if (got.event_res == EV_HDR) header_beats++;
         if (got.event_res == EV_VAL) value_beats++;
         if (got.event_res == EV_ERR) error_beats++;
         if (predicted_events.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("Unexpected result beat: ev=%0d tag=%h off=%0d",
                        got.event_res, got.tag_value, got.byte_offset);
            end
         end else begin
            want = predicted_events.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("Expected ev=%0d tag=%h len=%0d val=%h last=%b err=%0d off=%0d",
                           want.event_res, want.tag_value, want.item_length, want.value_byte,
                           want.last_of_value, want.error_code, want.byte_offset);
                  $display("  Actual ev=%0d tag=%h len=%0d val=%h last=%b err=%0d off=%0d",
                           got.event_res, got.tag_value, got.item_length, got.value_byte,
                           got.last_of_value, got.error_code, got.byte_offset);
               end
            end
         end
      end
   end

   initial begin : watchdog
      while (cycle_count < CycleLimit) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Run stopped at the cycle limit with %0d results outstanding.",
               predicted_events.size());
      $display("** der_tlv_stream_parser: FAILED **");
      $finish;
   end

   initial begin : stimulus
      logic [ByteWidth-1:0] stream [$];
      int unsigned          size_pick;
      int unsigned          size_eff;
      int unsigned          room;
      int unsigned          cap;
      int unsigned          nlen;
      int unsigned          vlen;
      int unsigned          max_len;
      int unsigned          pick;
      int                   phase_count;
      reset <= 1'b1;
      csr_write_enable <= 1'b0;
      csr_write_data <= '0;
      req_bus.valid <= 1'b0;
      req_bus.data_byte <= '0;
      phase_count = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (Script[i]) begin
         if (Script[i].write_size) begin
            write_buffer_size(Script[i].size);
         end else begin
            send_byte(Script[i].data, Script[i].typed, Script[i].beat);
         end
      end

      while (bytes_sent < ItemTarget) begin
         pick = $urandom_range(0, 99);
         if (pick < 4) size_pick = 0;
         else if (pick < 8) size_pick = MaxBuffer;
         else if (pick < 11) size_pick = 21'h1FFFFF;
         else if (pick < 15) size_pick = $urandom_range(0, 21'h1FFFFF);
         else if (pick < 25) size_pick = $urandom_range(65, 700);
         else size_pick = $urandom_range(1, 64);
         size_eff = (size_pick > MaxBuffer) ? MaxBuffer : size_pick;
         cap = (size_eff <= 700) ? 700 : $urandom_range(8, 160);
         room = (size_eff < cap) ? size_eff : cap;
         write_buffer_size(SizeWidth'(size_pick));
         no_gaps = ($urandom_range(0, 3) == 0);

         if ($urandom_range(0, 9) < 8) begin
            // Back-to-back items that fill the room, in short or long form.
            while (room > 0) begin
               if (room == 1) begin
                  stream = {stream, 8'($urandom)};
                  room = 0;
               end else begin
                  nlen = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : 0;
                  if (2 + nlen > room) nlen = 0;
                  max_len = room - 2 - nlen;
                  vlen = $urandom_range(0, (max_len < 12) ? max_len : 12);
                  if ($urandom_range(0, 9) == 0) vlen = $urandom_range(0, max_len);
                  if (nlen == 0 && vlen > 127) vlen = 127;
                  if (nlen == 1 && vlen > 255) vlen = 255;
                  stream = {stream, 8'($urandom)};
                  if (nlen == 0) begin
                     stream = {stream, vlen[7:0]};
                  end else begin
                     stream = {stream, (8'h80 | nlen[7:0])};
                     for (int k = int'(nlen) - 1; k >= 0; k--) begin
                        stream = {stream, ((k < 4) ? 8'(vlen >> (8 * k)) : 8'h00)};
                     end
                  end
                  repeat (vlen) stream = {stream, 8'($urandom)};
                  room = room - 2 - nlen - vlen;
               end
            end
            if (stream.size() != 0 && $urandom_range(0, 4) == 0) begin
               stream[$urandom_range(0, stream.size() - 1)] = 8'($urandom);
            end
            if (stream.size() == size_eff) begin
               repeat ($urandom_range(0, 2)) stream = {stream, 8'($urandom)};
            end
         end else begin
            repeat ($urandom_range(1, 24)) stream = {stream, 8'($urandom)};
         end

         if (stream.size() >= 8 && (holds_done == 0 || phase_count % 20 == 0)) begin
            long_hold = 1'b1;
            holds_done++;
         end
         foreach (stream[k]) send_byte(stream[k], 1'b0, NoBeat);
         stream.delete();
         phase_count++;
      end

      req_bus.valid <= 1'b0;
      while (predicted_events.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      $display("Sent %0d bytes (%0d parsed before an error) over %0d buffer size settings.",
               bytes_sent, live_bytes, size_writes);
      $display("Checked %0d beats: %0d headers, %0d value bytes, %0d errors, %0d long stalls.",
               beats_checked, header_beats, value_beats, error_beats, holds_done);
      if (mismatches == 0) begin
         $display("** der_tlv_stream_parser: PASSED **");
      end else begin
         $display("** der_tlv_stream_parser: FAILED **");
      end
      $finish;
   end

endmodule
